// ===== design/min_tracking_stack_macros.svh =====
// Assertion helpers shared by the stack RTL.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mts_pkg.sv =====
`timescale 1ns / 1ps

package mts_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 11;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]            op_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [COUNT_W-1:0]         count_t;

    localparam op_t OP_PUSH  = 2'd0;
    localparam op_t OP_POP   = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_POP_EMPTY = 2'd1;
    localparam status_t ST_PUSH_FULL = 2'd2;

endpackage

// ===== design/mts_if.sv =====
`timescale 1ns / 1ps

// Request channel: one operation per beat.
interface mts_in_if;
    logic              valid;
    logic              ready;
    mts_pkg::op_t      op;
    mts_pkg::value_t   push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

// Response channel: the stack state after each operation.
interface mts_out_if;
    logic               valid;
    logic               ready;
    mts_pkg::value_t    top_value;
    mts_pkg::value_t    min_value;
    logic               is_empty;
    mts_pkg::count_t    item_count;
    mts_pkg::status_t   status;

    modport source (output valid, output top_value, output min_value, output is_empty,
                    output item_count, output status, input ready);
    modport sink   (input valid, input top_value, input min_value, input is_empty,
                    input item_count, input status, output ready);
endinterface

// ===== design/min_tracking_stack.sv =====
// The response is registered on the same edge that accepts the request.
// Throughput: one request per cycle while the response side is ready; the top value, minimum and repeat count live in
// registers, and each store's single registered read prefetches the entry just below.
// Reset: pointers, running minimum and response valid clear at once; the stores are
// not cleared and need no clearing pass, since entries are read only below the pointers.
`timescale 1ns / 1ps
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
    parameter int DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    mts_in_if.sink     req,
    mts_out_if.source  rsp
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    typedef logic [PW-1:0] ptr_t;
    typedef logic [AW-1:0] addr_t;

    mts_pkg::value_t value_mem [DEPTH];
    mts_pkg::value_t min_mem   [DEPTH];
    ptr_t            rep_mem   [DEPTH];

    ptr_t            vptr_reg, vptr_next;
    ptr_t            mptr_reg, mptr_next;
    mts_pkg::value_t min_reg,  min_next;
    ptr_t            rep_reg,  rep_next;
    mts_pkg::value_t top_reg,  top_next;

    mts_pkg::value_t vs_rd_reg;
    mts_pkg::value_t ms_rd_reg;
    ptr_t            rep_rd_reg;

    logic             out_valid_reg;
    mts_pkg::value_t  out_top_reg;
    mts_pkg::value_t  out_min_reg;
    logic             out_empty_reg;
    mts_pkg::count_t  out_count_reg;
    mts_pkg::status_t out_status_reg;

    mts_pkg::status_t status_next;
    logic             acc;
    logic             empty_next;
    ptr_t             mptr_m1;
    ptr_t             vrd_ptr;
    ptr_t             mrd_ptr;
    logic             vs_re;
    logic             ms_re;

    logic             vs_we;
    addr_t            vs_waddr;
    mts_pkg::value_t  vs_wdata;
    logic             ms_we;
    addr_t            ms_waddr;
    mts_pkg::value_t  ms_wdata;
    logic             rep_we;
    addr_t            rep_waddr;
    ptr_t             rep_wdata;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign acc       = req.valid && req.ready;
    assign mptr_m1   = mptr_reg - ptr_t'(1);

    always_comb
    begin
        vptr_next   = vptr_reg;
        mptr_next   = mptr_reg;
        min_next    = min_reg;
        rep_next    = rep_reg;
        top_next    = top_reg;
        status_next = mts_pkg::ST_OK;
        vs_we       = 1'b0;
        vs_waddr    = vptr_reg[AW-1:0];
        vs_wdata    = req.push_value;
        ms_we       = 1'b0;
        ms_waddr    = mptr_reg[AW-1:0];
        ms_wdata    = req.push_value;
        rep_we      = 1'b0;
        rep_waddr   = mptr_reg[AW-1:0];
        rep_wdata   = ptr_t'(1);
        if (acc)
        begin
            unique case (req.op)
                mts_pkg::OP_PUSH:
                begin
                    if (vptr_reg == ptr_t'(DEPTH))
                    begin
                        status_next = mts_pkg::ST_PUSH_FULL;
                    end
                    else
                    begin
                        vs_we     = 1'b1;
                        top_next  = req.push_value;
                        vptr_next = vptr_reg + ptr_t'(1);
                        if (vptr_reg == '0)
                        begin
                            // First value restarts the pair stack.
                            min_next  = req.push_value;
                            rep_next  = ptr_t'(1);
                            mptr_next = ptr_t'(1);
                            ms_we     = 1'b1;
                            ms_waddr  = '0;
                            rep_we    = 1'b1;
                            rep_waddr = '0;
                        end
                        else if (req.push_value <= min_reg)
                        begin
                            min_next = req.push_value;
                            if (mptr_reg != '0 && min_reg == req.push_value)
                            begin
                                rep_next  = rep_reg + ptr_t'(1);
                                rep_we    = 1'b1;
                                rep_waddr = mptr_m1[AW-1:0];
                                rep_wdata = rep_reg + ptr_t'(1);
                            end
                            else if (mptr_reg != ptr_t'(DEPTH))
                            begin
                                rep_next  = ptr_t'(1);
                                mptr_next = mptr_reg + ptr_t'(1);
                                ms_we     = 1'b1;
                                rep_we    = 1'b1;
                            end
                        end
                    end
                end
                mts_pkg::OP_POP:
                begin
                    if (vptr_reg == '0)
                    begin
                        status_next = mts_pkg::ST_POP_EMPTY;
                    end
                    else
                    begin
                        vptr_next = vptr_reg - ptr_t'(1);
                        top_next  = vs_rd_reg;
                        if (mptr_reg != '0 && min_reg == top_reg)
                        begin
                            if (rep_reg > ptr_t'(1))
                            begin
                                rep_next  = rep_reg - ptr_t'(1);
                                rep_we    = 1'b1;
                                rep_waddr = mptr_m1[AW-1:0];
                                rep_wdata = rep_reg - ptr_t'(1);
                            end
                            else
                            begin
                                // The pair is used up; fall back to the one below.
                                mptr_next = mptr_m1;
                                if (mptr_reg > ptr_t'(1))
                                begin
                                    min_next = ms_rd_reg;
                                    rep_next = rep_rd_reg;
                                end
                                else
                                begin
                                    min_next = '0;
                                end
                            end
                        end
                    end
                end
                mts_pkg::OP_CLEAR:
                begin
                    vptr_next = '0;
                    mptr_next = '0;
                    min_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The prefetch always targets the entries just below the next tops, which no write
    // of the same edge touches.
    assign vrd_ptr    = vptr_next - ptr_t'(2);
    assign mrd_ptr    = mptr_next - ptr_t'(2);
    assign vs_re      = vptr_next >= ptr_t'(2);
    assign ms_re      = mptr_next >= ptr_t'(2);
    assign empty_next = vptr_next == '0;

    always_ff @(posedge clk)
    begin
        if (vs_we)
        begin
            value_mem[vs_waddr] <= vs_wdata;
        end
        if (vs_re)
        begin
            vs_rd_reg <= value_mem[vrd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ms_we)
        begin
            min_mem[ms_waddr] <= ms_wdata;
        end
        if (ms_re)
        begin
            ms_rd_reg <= min_mem[mrd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rep_we)
        begin
            rep_mem[rep_waddr] <= rep_wdata;
        end
        if (ms_re)
        begin
            rep_rd_reg <= rep_mem[mrd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vptr_reg      <= '0;
            mptr_reg      <= '0;
            min_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vptr_reg <= vptr_next;
            mptr_reg <= mptr_next;
            min_reg  <= min_next;
            if (acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep_next;
        top_reg <= top_next;
        if (acc)
        begin
            out_top_reg    <= empty_next ? '0 : top_next;
            out_min_reg    <= empty_next ? '0 : min_next;
            out_empty_reg  <= empty_next;
            out_count_reg  <= mts_pkg::COUNT_W'(vptr_next);
            out_status_reg <= status_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.top_value  = out_top_reg;
    assign rsp.min_value  = out_min_reg;
    assign rsp.is_empty   = out_empty_reg;
    assign rsp.item_count = out_count_reg;
    assign rsp.status     = out_status_reg;

    `MTS_ASSERT_NOW(a_pairs_le_values, clk, rst_n, 1'b1, mptr_reg <= vptr_reg, "pair stack deeper than value stack")
    `MTS_ASSERT_NEXT(a_pop_decrements, clk, rst_n, acc && req.op == mts_pkg::OP_POP && vptr_reg != '0, vptr_reg == $past(vptr_reg) - ptr_t'(1), "pop did not remove one value")
    `MTS_ASSERT_NEXT(a_full_push_dropped, clk, rst_n, acc && req.op == mts_pkg::OP_PUSH && vptr_reg == ptr_t'(DEPTH), $stable(vptr_reg) && rsp.status == mts_pkg::ST_PUSH_FULL, "push on full not dropped")

endmodule
